// ===== rtl/hsfd_pkg.sv =====
// hsfd_pkg: shared types, constants and arithmetic helpers for the
// humidity sensor frame decoder. No dependencies.
package hsfd_pkg;

    // Sensor family codes
    localparam logic [1:0] FAM_NEWER  = 2'd0;
    localparam logic [1:0] FAM_OLDER  = 2'd1;
    localparam logic [1:0] FAM_LEGACY = 2'd2;

    // Frame byte positions
    localparam logic [2:0] POS_T_HI   = 3'd0;
    localparam logic [2:0] POS_T_LO   = 3'd1;
    localparam logic [2:0] POS_T_CRC  = 3'd2;
    localparam logic [2:0] POS_H_HI   = 3'd3;
    localparam logic [2:0] POS_H_LO   = 3'd4;
    localparam logic [2:0] POS_H_CRC  = 3'd5;

    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h31;

    // Scale factors and offsets
    localparam logic [14:0] K_TEMP        = 15'd17500;
    localparam logic [14:0] K_TEMP_LEGACY = 15'd17572;
    localparam logic [13:0] K_HUM         = 14'd12500;
    localparam logic [13:0] K_HUM_OLDER   = 14'd10000;
    localparam logic signed [15:0] OFS_TEMP        = 16'sd4500;
    localparam logic signed [15:0] OFS_TEMP_LEGACY = 16'sd4685;
    localparam logic signed [15:0] OFS_HUM         = 16'sd600;
    localparam logic signed [15:0] HUM_MAX         = 16'sd10000;
    localparam logic [15:0] LEGACY_MASK  = 16'hFFFC;

    // One completed frame handed from front to back
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        crc_bad;
    } hsfd_frame_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    // floor(n / 65535) for n < 2^31 with n >> 16 small: n = q0*65535 + (q0 + lo)
    function automatic logic [15:0] div65535(input logic [30:0] n);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = n[30:16];
        r  = {1'b0, n[15:0]} + {2'b0, q0};
        return {1'b0, q0} + ((r >= 17'd65535) ? 16'd1 : 16'd0);
    endfunction

endpackage

// ===== rtl/hsfd_front.sv =====
// hsfd_front: byte intake, CRC-8 checking and word assembly.
// Depends on hsfd_pkg; pushes one hsfd_frame_t per complete frame.
module hsfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                push,
    output hsfd_pkg::hsfd_frame_t push_frame
);
    import hsfd_pkg::*;

    logic [2:0]  pos_reg,  pos_next;
    logic [7:0]  crc_reg,  crc_next;
    logic [15:0] word_reg, word_next;
    logic [15:0] temp_reg, temp_next;
    logic        fail_reg, fail_next;
    logic [2:0]  pos;
    logic        mismatch;

    // effective position of this byte
    assign pos      = (frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
    assign mismatch = (crc_reg != rx_byte);

    // next state per position
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        word_next = word_reg;
        temp_next = temp_reg;
        fail_next = fail_reg;
        if (accept)
        begin
            pos_next = (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
            unique case (pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc_next  = crc8_byte(CRC_INIT, rx_byte);
                    word_next = {rx_byte, 8'h00};
                    if (pos == POS_T_HI)
                    begin
                        fail_next = 1'b0;
                    end
                end
                POS_T_LO, POS_H_LO:
                begin
                    crc_next  = crc8_byte(crc_reg, rx_byte);
                    word_next = {word_reg[15:8], rx_byte};
                end
                POS_T_CRC:
                begin
                    crc_next  = CRC_INIT;
                    fail_next = fail_reg | mismatch;
                    temp_next = word_reg;
                end
                default:
                begin
                    crc_next  = CRC_INIT;
                    fail_next = 1'b0;
                end
            endcase
        end
    end

    // hand the frame to the queue on its last byte
    assign push                 = accept && (pos == POS_H_CRC);
    assign push_frame.temp_word = temp_reg;
    assign push_frame.hum_word  = word_reg;
    assign push_frame.crc_bad   = fail_reg | mismatch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_T_HI;
            crc_reg  <= CRC_INIT;
            word_reg <= '0;
            temp_reg <= '0;
            fail_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            word_reg <= word_next;
            temp_reg <= temp_next;
            fail_reg <= fail_next;
        end
    end

endmodule

// ===== rtl/hsfd_queue.sv =====
// hsfd_queue: two-entry frame queue between front and back.
// Depends on hsfd_pkg for hsfd_frame_t.
module hsfd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hsfd_pkg::hsfd_frame_t push_frame,
    input  logic                  pop,
    output logic                  full,
    output logic                  q_valid,
    output hsfd_pkg::hsfd_frame_t q_frame
);
    import hsfd_pkg::*;

    hsfd_frame_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_frame = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/hsfd_back.sv =====
// hsfd_back: two-stage conversion of a frame to centidegrees/centipercent.
// Depends on hsfd_pkg (constants, div65535). Stage 1 multiplies, stage 2
// divides by 65535 or 65536, offsets, clamps, and holds the output item.
module hsfd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            family,
    input  logic                  q_valid,
    input  hsfd_pkg::hsfd_frame_t q_frame,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic signed [14:0]    temperature,
    output logic signed [14:0]    humidity,
    output logic                  status
);
    import hsfd_pkg::*;

    logic        s1_valid_reg;
    logic [30:0] tprod_reg;
    logic [29:0] hprod_reg;
    logic        bad_reg, legacy_reg, older_reg, clamp_reg;
    logic        out_valid_reg;
    logic signed [14:0] temp_reg, hum_reg;
    logic        status_reg;

    logic        out_ready, s1_ready;
    logic        legacy;
    logic [15:0] tw, hw;
    logic [14:0] kt;
    logic [13:0] kh;
    logic [15:0] tq, hq;
    logic signed [15:0] t_val, h_val;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = q_valid && s1_ready;

    // stage 1 operands
    assign legacy = family[1];
    assign tw     = legacy ? (q_frame.temp_word & LEGACY_MASK) : q_frame.temp_word;
    assign hw     = legacy ? (q_frame.hum_word & LEGACY_MASK) : q_frame.hum_word;
    assign kt     = legacy ? K_TEMP_LEGACY : K_TEMP;
    assign kh     = (family == FAM_OLDER) ? K_HUM_OLDER : K_HUM;

    // stage 2: scale division and offsets
    always_comb
    begin
        tq = legacy_reg ? {1'b0, tprod_reg[30:16]} : div65535(tprod_reg);
        hq = legacy_reg ? {2'b0, hprod_reg[29:16]} : div65535({1'b0, hprod_reg});
        t_val = $signed(tq) - (legacy_reg ? OFS_TEMP_LEGACY : OFS_TEMP);
        h_val = older_reg ? $signed(hq) : ($signed(hq) - OFS_HUM);
        if (clamp_reg)
        begin
            if (h_val < 16'sd0)
            begin
                h_val = 16'sd0;
            end
            else if (h_val > HUM_MAX)
            begin
                h_val = HUM_MAX;
            end
        end
        if (bad_reg)
        begin
            t_val = 16'sd0;
            h_val = 16'sd0;
        end
    end

    // stage 1 payload and output registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tprod_reg  <= {16'd0, kt} * {15'd0, tw};
            hprod_reg  <= {16'd0, kh} * {14'd0, hw};
            bad_reg    <= !legacy && q_frame.crc_bad;
            legacy_reg <= legacy;
            older_reg  <= (family == FAM_OLDER);
            clamp_reg  <= (family == FAM_NEWER);
        end
        if (s1_valid_reg && out_ready)
        begin
            temp_reg   <= t_val[14:0];
            hum_reg    <= h_val[14:0];
            status_reg <= bad_reg;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= q_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temp_reg;
    assign humidity    = hum_reg;
    assign status      = status_reg;

endmodule

// ===== rtl/humidity_sensor_frame_decoder_core.sv =====
// humidity_sensor_frame_decoder_core: top level of the frame decoder.
// Depends on hsfd_pkg, hsfd_front, hsfd_queue and hsfd_back.
//
//   channel  | signals                                  | handshake
//   ---------+------------------------------------------+----------------------
//   input    | rx_byte[7:0], frame_start                | in_valid / in_stall
//   output   | temperature[14:0], humidity[14:0], status| out_valid / out_stall
//   config   | cfg_data[1:0] (sensor family)            | cfg_valid / cfg_ready
//
// One byte is taken every cycle while in_stall is low; CRC and word assembly
// finish in the cycle of the byte. A frame's result passes through the queue
// write, multiply stage and divide/offset stage into the output register.
// Reset clears positions, CRC and all valids; family resets to 0.
// in_stall rises only when the two-entry frame queue is full, which needs
// out_stall held for several frames.
module humidity_sensor_frame_decoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature,
    output logic signed [14:0] humidity,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);
    import hsfd_pkg::*;

    logic        family_reg;
    logic [1:0]  fam_reg;
    logic        accept;
    logic        push, pop, full, q_valid;
    hsfd_frame_t push_frame, q_frame;

    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // sensor family register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fam_reg    <= FAM_NEWER;
            family_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fam_reg    <= cfg_data;
            family_reg <= 1'b1;
        end
    end

    hsfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .frame_start(frame_start),
        .push       (push),
        .push_frame (push_frame)
    );

    hsfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (full),
        .q_valid    (q_valid),
        .q_frame    (q_frame)
    );

    hsfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .family     (family_reg ? fam_reg : FAM_NEWER),
        .q_valid    (q_valid),
        .q_frame    (q_frame),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .temperature(temperature),
        .humidity   (humidity),
        .status     (status)
    );

endmodule

// ===== rtl/hsfd_checker.sv =====
// hsfd_checker: port-level checks on the frame decoder top level.
// No package dependency; bound to humidity_sensor_frame_decoder_core below.
module hsfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [14:0] temperature,
    input logic signed [14:0] humidity,
    input logic               status
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature)
            && $stable(humidity) && $stable(status))
        else $error("output item changed while stalled");

    // a failed frame carries zero readings
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> temperature == 15'sd0 && humidity == 15'sd0)
        else $error("CRC failure with nonzero readings");

    // readings stay in the sensor range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature >= -15'sd4685 && temperature <= 15'sd13000)
        else $error("temperature out of range");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity >= -15'sd600 && humidity <= 15'sd11900)
        else $error("humidity out of range");

    // the input is never stalled while no result is held back
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && $past(!out_valid, 2) |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (.*);
